FILE: rtl/cete_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cete_pkg
// Shared types and constants for the clique energy table engine.
// ----------------------------------------------------------------------------
package cete_pkg;

  localparam int MAX_CLIQUE  = 8;
  localparam int VALUE_WIDTH = 32;
  localparam int TBL_DEPTH   = 1 << MAX_CLIQUE;
  localparam int IDX_W       = MAX_CLIQUE;
  localparam int NODE_W      = 3;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_PUSH  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_QRD,
    ST_QACC,
    ST_PRDU,
    ST_PRDV,
    ST_PWRU,
    ST_PWRV,
    ST_TINIT,
    ST_TRD,
    ST_TCHK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [7:0]         table_index;
    logic signed [31:0] table_value;
    logic               last_load;
    logic [2:0]         from_node;
    logic [2:0]         to_node;
    logic signed [31:0] push_amount;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] exchange_capacity;
    logic               capacity_nonzero;
    logic               status;
  } out_beat_t;

  // Memory port bundle driven by the sequencer.
  typedef struct packed {
    logic                   we;
    logic [IDX_W-1:0]       addr;
    logic [VALUE_WIDTH-1:0] wdata;
  } mem_req_t;

endpackage

FILE: rtl/cete_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cete_ram
// Generic single-port RAM with a registered read.
// ----------------------------------------------------------------------------
module cete_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One address per cycle; the read returns the old entry, also on a write.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: rtl/cete_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cete_seq
// Sequencer: walks the energy table for loads, queries, pushes and the
// tight set rebuild, and holds the tight sets and the result register.
// ----------------------------------------------------------------------------
module cete_seq (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [3:0]                     size_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  cete_pkg::in_beat_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output cete_pkg::out_beat_t            out_data,
  output cete_pkg::mem_req_t             mem_req,
  input  logic [cete_pkg::VALUE_WIDTH-1:0] mem_rdata
);
  import cete_pkg::*;

  state_t state_r, state_nxt;
  in_beat_t item_r;
  logic [IDX_W-1:0] full_r, um_r, vm_r, rest_r, s_r, s_nxt;
  logic [VALUE_WIDTH-1:0] best_r, uval_r, vval_r, delta_w;
  logic first_r;
  logic [IDX_W-1:0] tight_r [MAX_CLIQUE];
  logic [IDX_W-1:0] tv_r;
  logic out_valid_r;
  out_beat_t out_r;
  logic [IDX_W-1:0] us_w, vs_w;
  logic [3:0] n_w;
  logic [IDX_W-1:0] full_w;
  logic accept;

  // Effective clique size, clamped to the supported range.
  always_comb begin
    if (size_n < 4'd2) n_w = 4'd2;
    else if (size_n > 4'(MAX_CLIQUE)) n_w = 4'(MAX_CLIQUE);
    else n_w = size_n;
    full_w = IDX_W'((9'd1 << n_w) - 9'd1);
  end

  assign us_w    = s_r | um_r;
  assign vs_w    = s_r | vm_r;
  assign s_nxt   = (s_r - 1'b1) & rest_r;
  assign delta_w = VALUE_WIDTH'(item_r.push_amount);
  assign accept  = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE) || out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_DONE;
          if (in_data.cmd == CMD_LOAD) begin
            if ({1'b0, in_data.table_index} <= {1'b0, full_w} && in_data.last_load)
              state_nxt = ST_TINIT;
          end else if (in_data.cmd == CMD_QUERY || in_data.cmd == CMD_PUSH) begin
            if ({1'b0, in_data.from_node} < n_w && {1'b0, in_data.to_node} < n_w)
              state_nxt = (in_data.cmd == CMD_QUERY) ? ST_QRD : ST_PRDU;
          end
        end
      end
      ST_QRD:  state_nxt = ST_QACC;
      ST_QACC: state_nxt = (s_nxt == rest_r) ? ST_DONE : ST_QRD;
      ST_PRDU: state_nxt = ST_PRDV;
      ST_PRDV: state_nxt = ST_PWRU;
      ST_PWRU: state_nxt = ST_PWRV;
      ST_PWRV: state_nxt = (s_nxt == rest_r) ? ST_TINIT : ST_PRDU;
      ST_TINIT: state_nxt = (full_r > IDX_W'(1)) ? ST_TRD : ST_DONE;
      ST_TRD:  state_nxt = ST_TCHK;
      ST_TCHK: state_nxt = (tv_r == IDX_W'(1)) ? ST_DONE : ST_TRD;
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Memory port driven from the current state.
  always_comb begin
    mem_req = '0;
    unique case (state_r)
      ST_IDLE: begin
        mem_req.addr  = in_data.table_index;
        mem_req.wdata = VALUE_WIDTH'(in_data.table_value);
        mem_req.we    = accept && in_data.cmd == CMD_LOAD &&
                        {1'b0, in_data.table_index} <= {1'b0, full_w};
      end
      ST_QRD, ST_PRDU: mem_req.addr = us_w;
      ST_PRDV:         mem_req.addr = vs_w;
      ST_PWRU: begin
        mem_req.we    = 1'b1;
        mem_req.addr  = us_w;
        mem_req.wdata = uval_r - delta_w;
      end
      // When both nodes match, the entry just written is the one updated
      // again, so the two updates cancel.
      ST_PWRV: begin
        mem_req.we    = 1'b1;
        mem_req.addr  = vs_w;
        mem_req.wdata = (um_r == vm_r) ? uval_r : vval_r + delta_w;
      end
      ST_TRD:  mem_req.addr = tv_r;
      default: mem_req = '0;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_CLIQUE; i++) tight_r[i] <= '1;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      if (state_r == ST_DONE) out_valid_r <= 1'b1;
      if (state_r == ST_TINIT) begin
        for (int i = 0; i < MAX_CLIQUE; i++) tight_r[i] <= full_r;
      end
      // Walk downward so the smallest zero subset wins.
      if (state_r == ST_TCHK && mem_rdata == '0) begin
        for (int i = 0; i < MAX_CLIQUE; i++) begin
          if (tv_r[i]) tight_r[i] <= tv_r;
        end
      end
    end
  end

  // Payload and walk registers.
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          item_r  <= in_data;
          full_r  <= full_w;
          um_r    <= IDX_W'(1) << in_data.from_node;
          vm_r    <= IDX_W'(1) << in_data.to_node;
          rest_r  <= full_w & ~((IDX_W'(1) << in_data.from_node) |
                                (IDX_W'(1) << in_data.to_node));
          s_r     <= full_w & ~((IDX_W'(1) << in_data.from_node) |
                                (IDX_W'(1) << in_data.to_node));
          first_r <= 1'b1;
          out_r   <= '0;
          if (!(in_data.cmd == CMD_LOAD && {1'b0, in_data.table_index} <= {1'b0, full_w}) &&
              !((in_data.cmd == CMD_QUERY || in_data.cmd == CMD_PUSH) &&
                {1'b0, in_data.from_node} < n_w && {1'b0, in_data.to_node} < n_w))
            out_r.status <= 1'b1;
        end
      end
      ST_QACC: begin
        if (first_r || $signed(mem_rdata) < $signed(best_r)) best_r <= mem_rdata;
        first_r <= 1'b0;
        s_r     <= s_nxt;
        if (s_nxt == rest_r) begin
          out_r.exchange_capacity <=
            (first_r || $signed(mem_rdata) < $signed(best_r)) ? mem_rdata : best_r;
          out_r.capacity_nonzero <= tight_r[item_r.from_node][item_r.to_node];
        end
      end
      ST_PRDV: uval_r <= mem_rdata;
      // The v-side read issued in the previous cycle lands here.
      ST_PWRU: vval_r <= mem_rdata;
      ST_PWRV: s_r <= s_nxt;
      ST_TINIT: tv_r <= full_r - 1'b1;
      ST_TCHK: tv_r <= tv_r - 1'b1;
      default: ;
    endcase
  end

endmodule

FILE: rtl/clique_energy_table_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clique_energy_table_engine
// Energy table of one clique with exchange capacity queries and flow pushes.
//
//   channel | direction | handshake           | beat
//   in      | input     | in_valid/in_stall   | in_beat_t
//   out     | output    | out_valid/out_stall | out_beat_t
//   cfg     | input     | cfg_we              | clique_size
//
// All table work goes through the one table memory port. A query or push
// walks every subset of the other nodes, 2^(n-2) subsets, or 2^(n-1) when
// both nodes match; a push, and a load marked last, end with a tight set
// rebuild. Ignored items return a status result and leave the table alone.
// One item is worked at a time; the next beat is taken once the result
// has left. Synchronous reset clears the tight sets to all ones and sets
// the clique size to two; the table is undefined until loaded.
// ----------------------------------------------------------------------------
module clique_energy_table_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [3:0]          cfg_clique_size,
  input  logic                in_valid,
  output logic                in_stall,
  input  cete_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output cete_pkg::out_beat_t out_data
);
  import cete_pkg::*;

  logic [3:0] size_r;
  mem_req_t mem_req;
  logic [VALUE_WIDTH-1:0] mem_rdata;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) size_r <= 4'd2;
    else if (cfg_we) size_r <= cfg_clique_size;
  end

  cete_seq u_seq (
    .clk, .rst_n, .size_n(size_r), .in_valid, .in_stall, .in_data,
    .out_valid, .out_stall, .out_data, .mem_req, .mem_rdata
  );

  cete_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(TBL_DEPTH)) u_table (
    .clk, .we(mem_req.we), .addr(mem_req.addr), .wdata(mem_req.wdata),
    .rdata(mem_rdata)
  );

endmodule

FILE: rtl/cete_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cete_checker
// Port-level checks for the clique energy table engine.
// ----------------------------------------------------------------------------
module cete_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input cete_pkg::out_beat_t out_data
);

  // A stalled result beat holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // An accepted beat blocks the input until its result is gone.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while busy");

  // A waiting result blocks the input.
  a_wait: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input open with result pending");

  // Ignored items, flagged by status, carry no capacity flag.
  a_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status |-> !out_data.capacity_nonzero)
    else $error("flag set on ignored item");

endmodule

bind clique_energy_table_engine cete_checker u_chk (
  .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .out_data
);

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking regression for the clique energy table engine. A directed
// table covers reset state, value extremes, every command and the ignored
// cases. Random traffic then runs over several clique sizes, with each table
// filled before use. Results are checked against an in-bench predictor.
// ----------------------------------------------------------------------------
module tb;
  import cete_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      cfg_we;
  logic [3:0] cfg_clique_size;
  logic      in_valid;
  logic      in_stall;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_beat_t out_data;

  clique_energy_table_engine dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_clique_size(cfg_clique_size),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  typedef struct {
    in_beat_t  beat;
    bit        typed;
    out_beat_t res;
  } dir_row_t;

  // Predictor state.
  logic [31:0] energy [TBL_DEPTH];
  logic [7:0]  tight [MAX_CLIQUE];
  logic [3:0]  size_reg;

  out_beat_t pending_results[$];
  int        error_count;
  bit        quiet;
  bit        hold_req;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog.
  initial begin
    #100ms;
    $display("clique_energy_table_engine regression: fail");
    $finish;
  end

  task automatic mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic int eff_nodes();
    if (size_reg < 2) return 2;
    if (size_reg > MAX_CLIQUE) return MAX_CLIQUE;
    return size_reg;
  endfunction

  // Tight set rebuild: smallest zero-energy proper nonzero subset per node.
  function automatic void rebuild_tight(int n);
    int full;
    full = (1 << n) - 1;
    for (int i = 0; i < MAX_CLIQUE; i++) tight[i] = full[7:0];
    for (int s = full - 1; s >= 1; s--) begin
      if (energy[s] == 32'd0) begin
        for (int i = 0; i < n; i++)
          if (s[i]) tight[i] = s[7:0];
      end
    end
  endfunction

  // Updates the predictor state for one beat and returns its result.
  function automatic out_beat_t apply_beat(in_beat_t b);
    out_beat_t r;
    int n, full, um, vm, rest, s, us, vs;
    bit first;
    logic signed [31:0] best;
    n = eff_nodes();
    full = (1 << n) - 1;
    r = '0;
    best = '0;
    first = 1'b1;
    case (cmd_t'(b.cmd))
      CMD_LOAD: begin
        if (b.table_index > full) begin
          r.status = 1'b1;
        end else begin
          energy[b.table_index] = b.table_value;
          if (b.last_load) rebuild_tight(n);
        end
      end
      CMD_QUERY, CMD_PUSH: begin
        if (b.from_node >= n || b.to_node >= n) begin
          r.status = 1'b1;
        end else begin
          um = 1 << b.from_node;
          vm = 1 << b.to_node;
          rest = full & ~(um | vm);
          s = rest;
          do begin
            us = (s | um) & (TBL_DEPTH - 1);
            vs = (s | vm) & (TBL_DEPTH - 1);
            if (b.cmd == CMD_QUERY) begin
              if (first || $signed(energy[us]) < best) best = energy[us];
              first = 1'b0;
            end else begin
              energy[us] = energy[us] - b.push_amount;
              energy[vs] = energy[vs] + b.push_amount;
            end
            s = (s - 1) & rest;
          end while (s != rest);
          if (b.cmd == CMD_QUERY) begin
            r.exchange_capacity = best;
            r.capacity_nonzero = tight[b.from_node][b.to_node];
          end else begin
            rebuild_tight(n);
          end
        end
      end
      default: r.status = 1'b1;
    endcase
    return r;
  endfunction

  function automatic in_beat_t mk(cmd_t c, int idx, logic [31:0] val, bit last,
                                  int u, int v, logic [31:0] d);
    in_beat_t b;
    b.cmd = c;
    b.table_index = idx[7:0];
    b.table_value = val;
    b.last_load = last;
    b.from_node = u[2:0];
    b.to_node = v[2:0];
    b.push_amount = d;
    return b;
  endfunction

  // Energy values lean toward zero so that tight sets are nontrivial.
  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 32'd0;
      4: return 32'h7fffffff;
      5: return 32'h80000000;
      6, 7: return $urandom_range(0, 20) - 10;
      default: return $urandom;
    endcase
  endfunction

  function automatic in_beat_t rand_beat(int n);
    in_beat_t b;
    int full, pick;
    full = (1 << n) - 1;
    b = mk(CMD_LOAD, $urandom_range(0, full), rand_value(), $urandom_range(0, 3) == 0,
           $urandom_range(0, n - 1), $urandom_range(0, n - 1), rand_value());
    // Payload bits outside the active fields still toggle freely.
    if ($urandom_range(0, 1)) b.push_amount = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      b.cmd = CMD_LOAD;
      if ($urandom_range(0, 9) == 0) b.table_index = 8'($urandom_range(0, 255));
    end else if (pick < 65) begin
      b.cmd = CMD_QUERY;
    end else if (pick < 92) begin
      b.cmd = CMD_PUSH;
    end else if (pick < 96) begin
      b.cmd = CMD_NONE;
    end else begin
      b.cmd = $urandom_range(0, 1) ? CMD_QUERY : CMD_PUSH;
      b.from_node = 3'($urandom_range(0, 7));
      b.to_node = 3'($urandom_range(0, 7));
    end
    return b;
  endfunction

  // Offers one beat and waits until it is taken.
  task automatic send_beat(input in_beat_t b, input bit typed, input out_beat_t res);
    out_beat_t pred;
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (in_stall);
    pred = apply_beat(b);
    pending_results.insert(pending_results.size(), typed ? res : pred);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_size(input logic [3:0] sz);
    cfg_we <= 1'b1;
    cfg_clique_size <= sz;
    @(posedge clk);
    cfg_we <= 1'b0;
    size_reg = sz;
    @(posedge clk);
  endtask

  // Writes every entry of the active table; the final one rebuilds.
  task automatic fill_table();
    int full;
    full = (1 << eff_nodes()) - 1;
    for (int i = 0; i <= full; i++)
      send_beat(mk(CMD_LOAD, i, rand_value(), i == full, 0, 0, $urandom), 1'b0, '0);
  endtask

  // Result checker.
  always @(posedge clk) begin
    out_beat_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatch("result beat with nothing expected");
      end else begin
        e = pending_results.pop_front();
        if (out_data.exchange_capacity !== e.exchange_capacity)
          mismatch($sformatf("exchange_capacity got %0d want %0d",
                             out_data.exchange_capacity, e.exchange_capacity));
        if (out_data.capacity_nonzero !== e.capacity_nonzero)
          mismatch($sformatf("capacity_nonzero got %b want %b",
                             out_data.capacity_nonzero, e.capacity_nonzero));
        if (out_data.status !== e.status)
          mismatch($sformatf("status got %b want %b", out_data.status, e.status));
      end
    end
  end

  // Receiver stall bursts, plus one long hold-off on request.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 6) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Main sequence.
  initial begin
    dir_row_t rows[$];
    logic [3:0] sizes[$];
    out_beat_t ok;
    out_beat_t bad;
    int per_phase;
    ok = '0;
    bad = '0;
    bad.status = 1'b1;
    error_count = 0;
    quiet = 1'b0;
    hold_req = 1'b0;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_clique_size <= 4'd0;
    in_valid <= 1'b0;
    in_data <= '0;
    for (int i = 0; i < TBL_DEPTH; i++) energy[i] = '0;
    for (int i = 0; i < MAX_CLIQUE; i++) tight[i] = 8'hff;
    size_reg = 4'd2;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table at the reset size of two nodes.
    rows.insert(rows.size(), '{mk(CMD_LOAD, 0, 32'd0, 0, 0, 0, 0), 1, ok});
    rows.insert(rows.size(), '{mk(CMD_LOAD, 1, 32'h7fffffff, 0, 0, 0, 0), 1, ok});
    rows.insert(rows.size(), '{mk(CMD_LOAD, 2, 32'h80000000, 0, 0, 0, 0), 1, ok});
    rows.insert(rows.size(), '{mk(CMD_LOAD, 3, 32'd0, 1, 0, 0, 0), 1, ok});
    rows.insert(rows.size(), '{mk(CMD_LOAD, 4, 32'd5, 1, 0, 0, 0), 1, bad});
    rows.insert(rows.size(), '{mk(CMD_LOAD, 255, 32'hffffffff, 1, 7, 7, 0), 1, bad});
    rows.insert(rows.size(), '{mk(CMD_NONE, 0, 32'd0, 0, 0, 1, 0), 1, bad});
    rows.insert(rows.size(), '{mk(CMD_QUERY, 0, 0, 0, 2, 0, 0), 1, bad});
    rows.insert(rows.size(), '{mk(CMD_PUSH, 0, 0, 0, 0, 7, 32'd1), 1, bad});
    rows.insert(rows.size(), '{mk(CMD_QUERY, 0, 0, 0, 0, 1, 0), 0, ok});
    rows.insert(rows.size(), '{mk(CMD_QUERY, 0, 0, 0, 1, 0, 0), 0, ok});
    rows.insert(rows.size(), '{mk(CMD_QUERY, 0, 0, 0, 0, 0, 0), 0, ok});
    rows.insert(rows.size(), '{mk(CMD_PUSH, 0, 0, 0, 1, 1, 32'd9), 0, ok});
    rows.insert(rows.size(), '{mk(CMD_PUSH, 0, 0, 0, 0, 1, 32'h7fffffff), 0, ok});
    rows.insert(rows.size(), '{mk(CMD_QUERY, 0, 0, 0, 0, 1, 0), 0, ok});
    rows.insert(rows.size(), '{mk(CMD_PUSH, 0, 0, 0, 1, 0, 32'h80000000), 0, ok});
    rows.insert(rows.size(), '{mk(CMD_QUERY, 0, 0, 0, 1, 0, 0), 0, ok});
    rows.insert(rows.size(), '{mk(CMD_LOAD, 1, 32'd0, 1, 0, 0, 0), 1, ok});
    rows.insert(rows.size(), '{mk(CMD_QUERY, 0, 0, 0, 0, 1, 0), 0, ok});
    rows.insert(rows.size(), '{mk(CMD_QUERY, 0, 0, 0, 1, 1, 0), 0, ok});
    foreach (rows[i]) send_beat(rows[i].beat, rows[i].typed, rows[i].res);
    drain();

    // Random phases over several sizes, out-of-range ones included.
    sizes = '{4'd0, 4'd8, 4'd3, 4'd15, 4'd5, 4'd1, 4'd4, 4'd6, 4'd7, 4'd2};
    per_phase = 46;
    foreach (sizes[p]) begin
      set_size(sizes[p]);
      if (p == sizes.size() - 1) quiet = 1'b1;
      fill_table();
      for (int k = 0; k < per_phase; k++) begin
        if (p == 2 && k == 10) hold_req = 1'b1;
        if (p == 4 && k == 30) begin
          // Sender pauses until all outstanding results are back.
          in_valid <= 1'b0;
          @(posedge clk);
          while (pending_results.size() != 0) @(posedge clk);
        end
        send_beat(rand_beat(eff_nodes()), 1'b0, '0);
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("clique_energy_table_engine regression: pass");
    end else begin
      $display("clique_energy_table_engine regression: fail");
    end
    $finish;
  end

endmodule

FILE: clique_energy_table_engine.f
rtl/cete_pkg.sv
rtl/cete_ram.sv
rtl/cete_seq.sv
rtl/clique_energy_table_engine.sv
rtl/cete_checker.sv
tb/tb.sv
